/* rtl/core/lpsc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the length-prefix to start-code converter.
// No dependencies.
package lpsc_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN  = 2'd2;
    localparam logic [1:0] STATUS_TRUNC    = 2'd3;

    localparam logic [2:0] PREFIX_TWO  = 3'd2;
    localparam logic [2:0] PREFIX_FOUR = 3'd4;

    localparam logic [1:0] SC_LAST_IDX  = 2'd3;
    localparam logic [7:0] SC_LAST_BYTE = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PREFIX  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DROP    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RK_NONE    = 2'd0,
        RK_PAYLOAD = 2'd1,
        RK_STATUS  = 2'd2,
        RK_START   = 2'd3
    } res_kind_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  prefix_count;
        logic [31:0] length_accum;
        logic [31:0] nal_remaining;
        logic [31:0] sample_remaining;
    } parse_state_t;

    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] data;
        logic [1:0] status;
    } res_desc_t;

endpackage

/* rtl/core/lpsc_step.sv */
`timescale 1ns / 1ps
// Next-state and result logic for one input byte.
// Depends on lpsc_pkg.
module lpsc_step (
    input  lpsc_pkg::parse_state_t state_cur,
    input  logic [2:0]             prefix_bytes,
    input  logic [7:0]             data_byte,
    input  logic                   sample_start,
    input  logic [31:0]            sample_size,
    output lpsc_pkg::parse_state_t state_new,
    output lpsc_pkg::res_desc_t    res
);
    import lpsc_pkg::*;

    parse_state_t s;
    logic [31:0]  sr_dec;
    logic [31:0]  accum_new;
    logic [2:0]   cnt_new;
    logic [31:0]  nal_dec;

    always_comb
    begin
        s = state_cur;
        if (sample_start)
        begin
            s.sample_remaining = sample_size;
            s.prefix_count     = 3'd0;
            s.length_accum     = 32'd0;
            s.nal_remaining    = 32'd0;
            s.phase            = (sample_size == 32'd0) ? PH_IDLE : PH_PREFIX;
        end

        sr_dec     = s.sample_remaining - 32'd1;
        accum_new  = {s.length_accum[23:0], data_byte};
        cnt_new    = s.prefix_count + 3'd1;
        nal_dec    = s.nal_remaining - 32'd1;
        res.kind   = RK_NONE;
        res.data   = data_byte;
        res.status = STATUS_OK;
        state_new  = s;

        unique case (s.phase)
            PH_PREFIX:
            begin
                state_new.sample_remaining = sr_dec;
                if (prefix_bytes != PREFIX_TWO && prefix_bytes != PREFIX_FOUR)
                begin
                    state_new.phase = PH_DROP;
                    res.kind        = RK_STATUS;
                    res.status      = STATUS_BAD_SIZE;
                end
                else if (cnt_new < prefix_bytes)
                begin
                    if (sr_dec == 32'd0)
                    begin
                        state_new.phase        = PH_IDLE;
                        state_new.prefix_count = 3'd0;
                        state_new.length_accum = 32'd0;
                        res.kind               = RK_STATUS;
                        res.status             = STATUS_TRUNC;
                    end
                    else
                    begin
                        state_new.prefix_count = cnt_new;
                        state_new.length_accum = accum_new;
                    end
                end
                else
                begin
                    state_new.prefix_count = 3'd0;
                    state_new.length_accum = 32'd0;
                    if (accum_new > sr_dec)
                    begin
                        state_new.phase = PH_DROP;
                        res.kind        = RK_STATUS;
                        res.status      = STATUS_OVERRUN;
                    end
                    else
                    begin
                        state_new.nal_remaining = accum_new;
                        if (accum_new != 32'd0)
                            state_new.phase = PH_PAYLOAD;
                        else
                            state_new.phase = (sr_dec == 32'd0) ? PH_IDLE : PH_PREFIX;
                        res.kind = RK_START;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (s.nal_remaining != 32'd0)
                    state_new.nal_remaining = nal_dec;
                if (s.sample_remaining != 32'd0)
                    state_new.sample_remaining = sr_dec;
                if (state_new.nal_remaining == 32'd0)
                    state_new.phase = (state_new.sample_remaining == 32'd0) ?
                                      PH_IDLE : PH_PREFIX;
                res.kind = RK_PAYLOAD;
            end
            PH_IDLE, PH_DROP:
            begin
                res.kind = RK_NONE;
            end
            default:
            begin
                res.kind = RK_NONE;
            end
        endcase
    end

endmodule

/* rtl/core/lpsc_out.sv */
`timescale 1ns / 1ps
// Output register: holds one result descriptor and expands a start code
// into its four bytes. Depends on lpsc_pkg.
module lpsc_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lpsc_pkg::res_desc_t res,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                free_next,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                is_start_code,
    output logic [1:0]          status,
    output logic                run_last
);
    import lpsc_pkg::*;

    logic      valid_reg, valid_next;
    res_desc_t desc_reg;
    logic [1:0] idx_reg, idx_next;
    logic      is_sc;
    logic      last;

    assign is_sc     = (desc_reg.kind == RK_START);
    assign last      = !is_sc || (idx_reg == SC_LAST_IDX);
    assign free_next = !valid_reg || (out_ready && last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            desc_reg <= res;
    end

    assign out_valid     = valid_reg;
    assign is_start_code = is_sc;
    assign byte_valid    = (desc_reg.kind != RK_STATUS);
    assign status        = (desc_reg.kind == RK_STATUS) ? desc_reg.status : STATUS_OK;
    assign run_last      = last;

    always_comb
    begin
        unique case (desc_reg.kind)
            RK_START:   out_byte = (idx_reg == SC_LAST_IDX) ? SC_LAST_BYTE : 8'h00;
            RK_PAYLOAD: out_byte = desc_reg.data;
            default:    out_byte = 8'h00;
        endcase
    end

endmodule

/* rtl/core/length_prefix_to_start_code_unit.sv */
`timescale 1ns / 1ps
// Top level of the length-prefix to start-code converter.
// Depends on lpsc_pkg, lpsc_step and lpsc_out.
//
// Converts length-prefixed NAL units (2- or 4-byte big-endian prefixes, set by
// cfg_wr_data) into start-code delimited bytes. One input byte is taken per
// cycle while the output register is free; a payload byte leaves as one output
// byte. A byte that completes a prefix produces a four-byte start code from
// the single output register; input waits until its last byte is taken.
// Errors give one status transaction and the rest of the sample is dropped.
// Write the prefix size only while no transaction is in flight.
module length_prefix_to_start_code_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        sample_start,
    input  logic [31:0] sample_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        is_start_code,
    output logic [1:0]  status,
    output logic        run_last
);
    import lpsc_pkg::*;

    logic [2:0]   prefix_bytes_reg;
    parse_state_t state_reg, state_next;
    res_desc_t    res;
    logic         in_accept;
    logic         free_next;

    assign in_ready  = free_next;
    assign in_accept = in_valid && in_ready;

    lpsc_step u_step (
        .state_cur    (state_reg),
        .prefix_bytes (prefix_bytes_reg),
        .data_byte    (data_byte),
        .sample_start (sample_start),
        .sample_size  (sample_size),
        .state_new    (state_next),
        .res          (res)
    );

    lpsc_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_accept && (res.kind != RK_NONE)),
        .res           (res),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .free_next     (free_next),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .is_start_code (is_start_code),
        .status        (status),
        .run_last      (run_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bytes_reg           <= PREFIX_FOUR;
            state_reg.phase            <= PH_IDLE;
            state_reg.prefix_count     <= 3'd0;
            state_reg.length_accum     <= 32'd0;
            state_reg.nal_remaining    <= 32'd0;
            state_reg.sample_remaining <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
                prefix_bytes_reg <= cfg_wr_data;
            if (in_accept)
                state_reg <= state_next;
        end
    end

endmodule

/* tb/tb_length_prefix_to_start_code_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for length_prefix_to_start_code_unit: queued byte driver,
// clocked monitor with a built-in conversion predictor. Depends on lpsc_pkg and the RTL.
module tb_length_prefix_to_start_code_unit;
    import lpsc_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        start;
        logic [31:0] size;
    } sample_byte_t;

    typedef struct packed {
        logic [7:0] b;
        logic       bv;
        logic       sc;
        logic [1:0] st;
        logic       last;
    } annexb_res_t;

    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int RAND_ITEMS    = 260;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_wr_data   = 3'd0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte     = 8'd0;
    logic        sample_start  = 1'b0;
    logic [31:0] sample_size   = 32'd0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_start_code;
    logic [1:0]  status;
    logic        run_last;

    sample_byte_t byte_q[$];
    annexb_res_t  annexb_q[$];

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    bit   no_gaps  = 1'b0;
    int   hold_reqs = 0;
    int   fail_cnt = 0;
    int   stim_cnt = 0;

    // predictor state
    logic [2:0]  cfg_prefix  = PREFIX_FOUR;
    phase_t      st_phase    = PH_IDLE;
    logic [2:0]  st_pfx_cnt  = 3'd0;
    logic [31:0] st_len_acc  = 32'd0;
    logic [31:0] st_nal_left = 32'd0;
    logic [31:0] st_smp_left = 32'd0;

    length_prefix_to_start_code_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .sample_start  (sample_start),
        .sample_size   (sample_size),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .is_start_code (is_start_code),
        .status        (status),
        .run_last      (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_result(input logic [7:0] b, input logic bv, input logic sc,
                               input logic [1:0] st, input logic last);
        annexb_res_t r;
        r.b    = b;
        r.bv   = bv;
        r.sc   = sc;
        r.st   = st;
        r.last = last;
        annexb_q.push_back(r);
    endtask

    task automatic convert_byte(input sample_byte_t it);
        if (it.start)
        begin
            st_smp_left = it.size;
            st_pfx_cnt  = 3'd0;
            st_len_acc  = 32'd0;
            st_nal_left = 32'd0;
            st_phase    = (it.size == 32'd0) ? PH_IDLE : PH_PREFIX;
        end
        if (st_phase == PH_PREFIX)
        begin
            st_smp_left = st_smp_left - 32'd1;
            if (cfg_prefix != PREFIX_TWO && cfg_prefix != PREFIX_FOUR)
            begin
                st_phase = PH_DROP;
                push_result(8'd0, 1'b0, 1'b0, STATUS_BAD_SIZE, 1'b1);
            end
            else
            begin
                st_len_acc = {st_len_acc[23:0], it.data};
                st_pfx_cnt = st_pfx_cnt + 3'd1;
                if (st_pfx_cnt < cfg_prefix)
                begin
                    if (st_smp_left == 32'd0)
                    begin
                        st_phase   = PH_IDLE;
                        st_pfx_cnt = 3'd0;
                        st_len_acc = 32'd0;
                        push_result(8'd0, 1'b0, 1'b0, STATUS_TRUNC, 1'b1);
                    end
                end
                else
                begin
                    st_pfx_cnt = 3'd0;
                    if (st_len_acc > st_smp_left)
                    begin
                        st_phase   = PH_DROP;
                        st_len_acc = 32'd0;
                        push_result(8'd0, 1'b0, 1'b0, STATUS_OVERRUN, 1'b1);
                    end
                    else
                    begin
                        st_nal_left = st_len_acc;
                        st_len_acc  = 32'd0;
                        if (st_nal_left != 32'd0)
                            st_phase = PH_PAYLOAD;
                        else
                            st_phase = (st_smp_left == 32'd0) ? PH_IDLE : PH_PREFIX;
                        push_result(8'h00, 1'b1, 1'b1, STATUS_OK, 1'b0);
                        push_result(8'h00, 1'b1, 1'b1, STATUS_OK, 1'b0);
                        push_result(8'h00, 1'b1, 1'b1, STATUS_OK, 1'b0);
                        push_result(SC_LAST_BYTE, 1'b1, 1'b1, STATUS_OK, 1'b1);
                    end
                end
            end
        end
        else if (st_phase == PH_PAYLOAD)
        begin
            if (st_nal_left != 32'd0)
                st_nal_left = st_nal_left - 32'd1;
            if (st_smp_left != 32'd0)
                st_smp_left = st_smp_left - 32'd1;
            if (st_nal_left == 32'd0)
                st_phase = (st_smp_left == 32'd0) ? PH_IDLE : PH_PREFIX;
            push_result(it.data, 1'b1, 1'b0, STATUS_OK, 1'b1);
        end
    endtask

    // monitor: input transactions feed the predictor, output transactions are checked
    always @(posedge clk)
    begin : monitor_proc
        annexb_res_t got;
        annexb_res_t want;
        sample_byte_t it;
        in_fire  <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_byte, byte_valid, is_start_code, status, run_last};
            if (annexb_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result byte=%02h valid=%0b sc=%0b status=%0d last=%0b",
                         $time, got.b, got.bv, got.sc, got.st, got.last);
            end
            else
            begin
                want = annexb_q.pop_front();
                if (got !== want)
                begin
                    fail_cnt++;
                    $display({"%0t: mismatch expected byte=%02h valid=%0b sc=%0b status=%0d ",
                              "last=%0b, actual byte=%02h valid=%0b sc=%0b status=%0d last=%0b"},
                             $time, want.b, want.bv, want.sc, want.st, want.last,
                             got.b, got.bv, got.sc, got.st, got.last);
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            it.data  = data_byte;
            it.start = sample_start;
            it.size  = sample_size;
            convert_byte(it);
        end
    end

    // driver: one queued byte per transaction, random gap after each unless no_gaps is set
    always @(negedge clk)
    begin : drive_proc
        logic nv;
        sample_byte_t it;
        int send_wait;
        if (rst_n)
        begin
            nv = in_valid && !in_fire;
            if (!nv)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (byte_q.size() != 0)
                begin
                    it = byte_q.pop_front();
                    data_byte    <= it.data;
                    sample_start <= it.start;
                    sample_size  <= it.size;
                    nv = 1'b1;
                    send_wait = no_gaps ? 0 : $urandom_range(0, 13);
                end
            end
            in_valid <= nv;
        end
        else
            send_wait = 0;
    end

    // receiver: random wait per result, plus long hold-offs on request
    always @(negedge clk)
    begin : recv_proc
        int rcv_wait;
        int hold_left;
        int holds_done;
        logic rdy;
        if (rst_n)
        begin
            if (holds_done != hold_reqs)
            begin
                holds_done = hold_reqs;
                hold_left  = LONG_HOLD;
            end
            if (out_fire)
                rcv_wait = no_gaps ? 0 : $urandom_range(0, 13);
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (rcv_wait > 0)
            begin
                rcv_wait--;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            out_ready <= rdy;
        end
        else
        begin
            rcv_wait   = 0;
            hold_left  = 0;
            holds_done = 0;
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic s, input logic [31:0] sz);
        sample_byte_t it;
        it.data  = d;
        it.start = s;
        it.size  = sz;
        byte_q.push_back(it);
        stim_cnt++;
    endtask

    task automatic settle();
        while (byte_q.size() != 0 || in_valid || annexb_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_prefix_size(input logic [2:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_prefix  = v;
    endtask

    // one sample of NAL units; shrink cuts the declared size, keep cuts the bytes sent
    task automatic queue_sample(input int lay, input int nals, input int shrink, input int keep);
        logic [7:0] body[$];
        int len;
        int total;
        int sz;
        int i;
        repeat (nals)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
            for (i = lay - 1; i >= 0; i--)
                body.push_back(8'(len >> (8 * i)));
            repeat (len) body.push_back(8'($urandom));
        end
        total = body.size();
        sz = (shrink >= total) ? 0 : total - shrink;
        if (keep <= 0 || keep > total)
            keep = total;
        for (i = 0; i < keep; i++)
            push_byte(body[i], i == 0, (i == 0) ? 32'(sz) : $urandom);
    endtask

    initial
    begin : stim_proc
        int target;
        int p;
        int k;
        int lay;
        int phase_base;
        logic [2:0] sel;
        logic [2:0] bad_sizes[6] = '{3'd0, 3'd1, 3'd3, 3'd5, 3'd6, 3'd7};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // byte while idle, zero-size sample
        push_byte(8'hFF, 1'b0, 32'h0);
        push_byte(8'hAA, 1'b1, 32'h0);
        // maximum size sample, two-byte NAL
        push_byte(8'h00, 1'b1, 32'hFFFF_FFFF);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h02, 1'b0, 32'h0);
        push_byte(8'hFF, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        // new sample mid-sample: zero-length NAL then truncated prefix
        push_byte(8'h00, 1'b1, 32'd7);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        // NAL overruns sample, then a dropped byte
        push_byte(8'h00, 1'b1, 32'd6);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h00, 1'b0, 32'h0);
        push_byte(8'h05, 1'b0, 32'h0);
        push_byte(8'h5A, 1'b0, 32'h0);
        // leave a prefix half done, then shrink the prefix size under it
        push_byte(8'h00, 1'b1, 32'd100);
        set_prefix_size(PREFIX_TWO);
        push_byte(8'h03, 1'b0, 32'h0);
        push_byte(8'h80, 1'b0, 32'h0);
        push_byte(8'h7F, 1'b0, 32'h0);
        push_byte(8'h55, 1'b0, 32'h0);
        push_byte(8'hFF, 1'b0, 32'h0);
        push_byte(8'hFF, 1'b0, 32'h0);
        // unsupported sizes at both ends of the register
        set_prefix_size(3'd0);
        push_byte(8'h11, 1'b1, 32'd3);
        push_byte(8'h22, 1'b0, 32'h0);
        set_prefix_size(3'd7);
        push_byte(8'h33, 1'b1, 32'd1);

        target = RAND_ITEMS;
        for (p = 0; stim_cnt < target; p++)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
                sel = PREFIX_TWO;
            else if (k < 8)
                sel = PREFIX_FOUR;
            else
                sel = bad_sizes[$urandom_range(0, 5)];
            set_prefix_size(sel);
            lay = (sel == PREFIX_TWO) ? 2 : 4;
            no_gaps = (p % 3 == 2);
            if (p == 1)
                hold_reqs++;
            phase_base = stim_cnt;
            while (stim_cnt - phase_base < 40 && stim_cnt < target)
            begin
                k = $urandom_range(0, 19);
                if (k <= 12)
                    queue_sample(lay, $urandom_range(1, 3), 0, 0);
                else if (k <= 14)
                    queue_sample(lay, $urandom_range(1, 3), $urandom_range(1, 4), 0);
                else if (k <= 16)
                    queue_sample(lay, $urandom_range(1, 3), 0, $urandom_range(1, 6));
                else if (k == 17)
                begin
                    push_byte(8'($urandom), 1'b1, $urandom);
                    repeat ($urandom_range(2, 7)) push_byte(8'($urandom), 1'b0, $urandom);
                end
                else if (k == 18)
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, $urandom);
                else
                    push_byte(8'($urandom), 1'b1, 32'h0);
            end
        end
        no_gaps = 1'b0;
        settle();

        if (fail_cnt == 0 && annexb_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
